>>> hw/rtl/fxalu_pkg.sv
// shared types and constants for the fixed-point alu
package fxalu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IntW  = 24;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MIN = 3'd4,
    CMD_MAX = 3'd5,
    CMD_INC = 3'd6,
    CMD_DEC = 3'd7
  } cmd_e;

  // per-transaction result carried alongside the divider row
  typedef struct packed {
    cmd_e             cmd;
    logic             neg;
    logic [DataW-1:0] simple;
    logic             gt;
    logic             eq;
    logic             lt;
    logic [IntW-1:0]  int_part;
    logic             dz;
  } side_t;

endpackage

>>> hw/rtl/fxalu_cell.sv
// one restoring-division step cell; registers a partial remainder and quotient
module fxalu_cell import fxalu_pkg::*; #(
  parameter int unsigned QW = 40,
  parameter int unsigned DW = 32,
  parameter int unsigned Pos = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW:0]   rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [DW-1:0] div_i,
  input  side_t         side_i,
  input  logic [63:0]   prod_i,
  output logic          valid_o,
  output logic [DW:0]   rem_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] div_o,
  output side_t         side_o,
  output logic [63:0]   prod_o
);

  logic [DW+1:0] trial;
  logic [DW:0]   shifted;
  logic [DW:0]   rem_d;
  logic [QW-1:0] quo_d;
  logic          bit_d;

  // shift in next dividend bit, try subtract
  always_comb begin
    shifted = {rem_i[DW-1:0], quo_i[QW-1-Pos]};
    trial   = {1'b0, shifted} - {2'b00, div_i};
    bit_d   = ~trial[DW+1];
    rem_d   = bit_d ? trial[DW:0] : shifted;
    quo_d   = quo_i;
    quo_d[QW-1-Pos] = bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      div_o  <= div_i;
      side_o <= side_i;
      prod_o <= prod_i;
    end
  end

endmodule

>>> hw/rtl/fixed_point_q24_8_alu.sv
// top level of the signed fixed-point alu: entry stage, divider cell row, output register
//
// channel   dir  tdata fields (lsb first)                        handshake
// s_axis    in   cmd[2:0], operand_a[34:3], operand_b[66:35]      tvalid/tready
// m_axis    out  result_raw, a_greater, a_equal, a_less,          tvalid/tready
//                integer_part, divide_by_zero
//
// one transaction accepted every cycle while the output register is empty or being read
// the depth is set by the row of restoring-division cells, one quotient bit each
// the multiplier is registered in the entry stage and rides the row with the result
// the whole row advances when the output register is empty or being read
// reset clears all valid bits; payload registers are not reset
module fixed_point_q24_8_alu import fxalu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // cmd, operand_a, operand_b, zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata   // result_raw, a_greater, a_equal, a_less,
                                      // integer_part, divide_by_zero, zero fill
);

  localparam int unsigned QW = DataW + FRAC_BITS;

  logic       adv;
  logic [2:0] cmd_in;
  logic signed [DataW-1:0] a, b;
  logic [DataW-1:0] ma, mb;
  logic [63:0] prod;
  side_t side_in;

  logic          v   [QW+1];
  logic [DataW:0] rem [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [DataW-1:0] dv [QW+1];
  side_t         sd  [QW+1];
  logic [63:0]   pr  [QW+1];

  logic          out_v_q;
  logic [63:0]   out_q, out_d;

  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // decode and compare at entry
  always_comb begin
    cmd_in = s_axis_tdata[2:0];
    a  = s_axis_tdata[34:3];
    b  = s_axis_tdata[66:35];
    ma = a[DataW-1] ? DataW'(-a) : DataW'(a);
    mb = b[DataW-1] ? DataW'(-b) : DataW'(b);
    prod = 64'(ma) * 64'(mb);
    side_in.cmd = cmd_e'(cmd_in);
    side_in.neg = a[DataW-1] ^ b[DataW-1];
    side_in.gt  = a > b;
    side_in.eq  = a == b;
    side_in.lt  = a < b;
    side_in.dz  = (cmd_e'(cmd_in) == CMD_DIV) && (b == '0);
    side_in.int_part = IntW'(a[DataW-1] ? -(ma >> FRAC_BITS) : (ma >> FRAC_BITS));
    case (cmd_e'(cmd_in))
      CMD_ADD: side_in.simple = a + b;
      CMD_SUB: side_in.simple = a - b;
      CMD_MIN: side_in.simple = (a < b) ? a : b;
      CMD_MAX: side_in.simple = (a > b) ? a : b;
      CMD_INC: side_in.simple = a + 1;
      CMD_DEC: side_in.simple = a - 1;
      default: side_in.simple = '0;
    endcase
  end

  // entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem[0] <= '0;
      quo[0] <= {ma, FRAC_BITS'(0)};
      dv[0]  <= mb;
      sd[0]  <= side_in;
      pr[0]  <= prod;
    end
  end

  // row of division cells
  for (genvar i = 0; i < QW; i++) begin : g_cell
    fxalu_cell #(.QW(QW), .DW(DataW), .Pos(i)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(v[i]), .rem_i(rem[i]), .quo_i(quo[i]), .div_i(dv[i]),
      .side_i(sd[i]), .prod_i(pr[i]),
      .valid_o(v[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]), .div_o(dv[i+1]),
      .side_o(sd[i+1]), .prod_o(pr[i+1])
    );
  end

  // final select, sign and rounding
  logic [63:0] pround;
  logic [DataW-1:0] mulm, divm, res;
  side_t fs;
  always_comb begin
    fs     = sd[QW];
    pround = pr[QW] + (64'd1 << (FRAC_BITS - 1));
    mulm   = DataW'(pround >> FRAC_BITS);
    divm   = quo[QW][DataW-1:0];
    case (fs.cmd)
      CMD_MUL: res = fs.neg ? -mulm : mulm;
      CMD_DIV: res = fs.dz ? '0 : (fs.neg ? -divm : divm);
      default: res = fs.simple;
    endcase
    out_d = {4'b0, fs.dz, fs.int_part, fs.lt, fs.eq, fs.gt, res};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // output holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
    else $error("output changed under stall");
  // flags exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $onehot({out_q[32], out_q[33], out_q[34]}))
    else $error("compare flags not one-hot");
  // divide by zero yields zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q[59] |-> out_q[31:0] == '0)
    else $error("nonzero result on divide by zero");

endmodule
